@@ sv/crde_pkg.sv @@
// Shared constants, codes and types of the character raster draw engine.
package crde_pkg;

  // Frame store geometry.
  localparam int COLS   = 50;
  localparam int ROWS   = 20;
  localparam int DEPTH  = COLS * ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Working width of coordinates: holds every corner sum of two 8-bit fields.
  localparam int CW = 10;

  // Counter width for spans, row lengths and row counts (at most 127).
  localparam int NW = 7;

  // Command codes.
  typedef enum logic [2:0] {
    MODE_CLEAR     = 3'd0,
    MODE_LINE      = 3'd1,
    MODE_FILL_RECT = 3'd2,
    MODE_OUT_RECT  = 3'd3,
    MODE_FILL_TRI  = 3'd4,
    MODE_OUT_TRI   = 3'd5,
    MODE_READ      = 3'd6
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LINE_LOAD,
    S_LINE_RUN,
    S_FILL_RUN,
    S_READ,
    S_READ_CAP,
    S_DONE
  } state_t;

  // Sign extension of an 8-bit field to the working width.
  function automatic logic signed [CW-1:0] sext8(input logic [7:0] v);
    sext8 = {{(CW-8){v[7]}}, v};
  endfunction

  // True when a cell lies inside the store.
  function automatic logic in_store(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y);
    in_store = (x >= 0) && (x < $signed(CW'(COLS))) &&
               (y >= 0) && (y < $signed(CW'(ROWS)));
  endfunction

endpackage

@@ sv/crde_cmd_if.sv @@
// Command channel: one draw command per beat.
interface crde_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [7:0] start_x;
  logic signed [7:0] start_y;
  logic signed [7:0] span_x;
  logic signed [7:0] span_y;
  logic [6:0]        upper_cut;
  logic [1:0]        direction;
  logic [7:0]        glyph;

  modport source (output valid, mode, start_x, start_y, span_x, span_y,
                  upper_cut, direction, glyph, input ready);
  modport sink   (input valid, mode, start_x, start_y, span_x, span_y,
                  upper_cut, direction, glyph, output ready);
endinterface

@@ sv/crde_res_if.sv @@
// Result channel: one result per command.
interface crde_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       outside;

  modport source (output valid, pixel_value, outside, input ready);
  modport sink   (input valid, pixel_value, outside, output ready);
endinterface

@@ sv/char_raster_draw_engine.sv @@
// Top level of the character raster draw engine: sequencer, shared step unit and frame store.
//
//   channel | dir | modport | carries
//   cmd     | in  | sink    | mode, start_x, start_y, span_x, span_y, upper_cut, direction, glyph
//   res     | out | source  | pixel_value, outside
//
// One cell is visited per cycle by a single shared step unit (one coordinate add and one
// bounds compare feeding one frame store write port). Each command is taken while idle and
// ends by storing its result; between, a clear walks COLS*ROWS cells, a fill its visited
// cells, a line loads and walks each segment, an in-store read addresses then captures.
// Reset is synchronous and active high; it clears the sequencer and the result valid flag
// but not the result data or the frame store. A new command is taken only when the
// sequencer is idle; a result is stored only once the previous result beat is accepted.
module char_raster_draw_engine
  import crde_pkg::*;
(
  input  logic clk,
  input  logic rst,
  crde_cmd_if.sink   cmd,
  crde_res_if.source res
);

  state_t state, state_next;

  // Latched command.
  mode_t                 cmd_mode;
  logic signed [CW-1:0]  cmd_x, cmd_y, cmd_px, cmd_py;
  logic [1:0]            cmd_dir;
  logic [7:0]            paint_glyph;

  // Shared walker position.
  logic signed [CW-1:0]  cur_x, cur_y;

  // Line segment state.
  logic signed [CW-1:0]  end_x, end_y;
  logic [1:0]            seg, seg_last;

  // Raster fill state.
  logic signed [CW-1:0]  row_x0;
  logic [NW-1:0]         col_left, rows_left, row_len;
  logic                  step_left, step_up, shrink;

  // Result register contents.
  logic [7:0]            res_value;
  logic                  res_outside;

  logic                  accept;
  logic                  fill_empty;
  logic signed [CW-1:0]  in_x, in_y, in_px, in_py, tri_rows;
  logic signed [CW-1:0]  seg_sx, seg_sy, seg_ex, seg_ey;
  logic signed [CW-1:0]  tri_dx, tri_dy;
  logic                  at_end, row_end, last_row;
  logic [NW-1:0]         row_len_next;

  logic                  we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [7:0]            rdata;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);

  assign in_x  = sext8(cmd.start_x);
  assign in_y  = sext8(cmd.start_y);
  assign in_px = sext8(cmd.span_x);
  assign in_py = sext8(cmd.span_y);
  assign tri_rows = in_px - CW'(cmd.upper_cut);

  // A filled shape with no cell skips straight to the result.
  always_comb begin
    fill_empty = 1'b0;
    case (cmd.mode)
      MODE_FILL_RECT: fill_empty = (in_px <= 0) || (in_py <= 0);
      MODE_FILL_TRI:  fill_empty = (in_px <= 0) || (tri_rows <= 0);
      default:        fill_empty = 1'b0;
    endcase
  end

  // End points of the current outline segment.
  assign tri_dx = (cmd_dir == 2'd2 || cmd_dir == 2'd3) ? -cmd_px : cmd_px;
  assign tri_dy = (cmd_dir == 2'd1 || cmd_dir == 2'd2) ? cmd_py : -cmd_py;

  always_comb begin
    seg_sx = cmd_x;
    seg_sy = cmd_y;
    seg_ex = cmd_px;
    seg_ey = cmd_py;
    case (cmd_mode)
      MODE_OUT_RECT: begin
        case (seg)
          2'd0: begin
            seg_sx = cmd_x;          seg_sy = cmd_y;
            seg_ex = cmd_x + cmd_px; seg_ey = cmd_y;
          end
          2'd1: begin
            seg_sx = cmd_x + cmd_px; seg_sy = cmd_y;
            seg_ex = cmd_x + cmd_px; seg_ey = cmd_y + cmd_py;
          end
          2'd2: begin
            seg_sx = cmd_x + cmd_px; seg_sy = cmd_y + cmd_py;
            seg_ex = cmd_x;          seg_ey = cmd_y + cmd_py;
          end
          default: begin
            seg_sx = cmd_x;          seg_sy = cmd_y + cmd_py;
            seg_ex = cmd_x;          seg_ey = cmd_y;
          end
        endcase
      end
      MODE_OUT_TRI: begin
        case (seg)
          2'd0: begin
            seg_sx = cmd_x + tri_dx; seg_sy = cmd_y;
            seg_ex = cmd_x;          seg_ey = cmd_y + tri_dy;
          end
          2'd1: begin
            seg_sx = cmd_x;          seg_sy = cmd_y;
            seg_ex = cmd_x + tri_dx; seg_ey = cmd_y;
          end
          default: begin
            seg_sx = cmd_x;          seg_sy = cmd_y;
            seg_ex = cmd_x;          seg_ey = cmd_y + tri_dy;
          end
        endcase
      end
      default: begin
        seg_sx = cmd_x;  seg_sy = cmd_y;
        seg_ex = cmd_px; seg_ey = cmd_py;
      end
    endcase
  end

  assign at_end       = (cur_x == end_x) && (cur_y == end_y);
  assign row_end      = (col_left == NW'(1));
  assign last_row     = (rows_left == NW'(1));
  assign row_len_next = shrink ? row_len - NW'(1) : row_len;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.mode)
            MODE_CLEAR:                  state_next = S_FILL_RUN;
            MODE_FILL_RECT, MODE_FILL_TRI:
              state_next = fill_empty ? S_DONE : S_FILL_RUN;
            MODE_LINE, MODE_OUT_RECT, MODE_OUT_TRI:
              state_next = S_LINE_LOAD;
            MODE_READ:
              state_next = in_store(in_x, in_y) ? S_READ : S_DONE;
            default:                     state_next = S_DONE;
          endcase
        end
      end
      S_LINE_LOAD: state_next = S_LINE_RUN;
      S_LINE_RUN: begin
        if (at_end) begin
          state_next = (seg == seg_last) ? S_DONE : S_LINE_LOAD;
        end
      end
      S_FILL_RUN: begin
        if (row_end && last_row) begin
          state_next = S_DONE;
        end
      end
      S_READ:     state_next = S_READ_CAP;
      S_READ_CAP: state_next = S_DONE;
      S_DONE: begin
        if (!res.valid || res.ready) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Frame store port control.
  always_comb begin
    we    = ((state == S_LINE_RUN) || (state == S_FILL_RUN)) && in_store(cur_x, cur_y);
    waddr = ADDR_W'(cur_y[NW-1:0]) * ADDR_W'(COLS) + ADDR_W'(cur_x[NW-1:0]);
    raddr = ADDR_W'(cmd_y[NW-1:0]) * ADDR_W'(COLS) + ADDR_W'(cmd_x[NW-1:0]);
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command latch and walker datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_mode    <= mode_t'(cmd.mode);
          cmd_x       <= in_x;
          cmd_y       <= in_y;
          cmd_px      <= in_px;
          cmd_py      <= in_py;
          cmd_dir     <= cmd.direction;
          paint_glyph <= cmd.glyph;
          seg         <= 2'd0;
          res_value   <= 8'd0;
          res_outside <= (cmd.mode == MODE_READ) && !in_store(in_x, in_y);
          case (cmd.mode)
            MODE_OUT_RECT: seg_last <= 2'd3;
            MODE_OUT_TRI:  seg_last <= 2'd2;
            default:       seg_last <= 2'd0;
          endcase
          // Raster set-up: a clear is a store-sized rectangle from the origin.
          case (cmd.mode)
            MODE_CLEAR: begin
              cur_x     <= '0;
              cur_y     <= '0;
              row_x0    <= '0;
              col_left  <= NW'(COLS);
              row_len   <= NW'(COLS);
              rows_left <= NW'(ROWS);
              step_left <= 1'b0;
              step_up   <= 1'b0;
              shrink    <= 1'b0;
            end
            MODE_FILL_TRI: begin
              cur_x     <= in_x;
              cur_y     <= in_y;
              row_x0    <= in_x;
              col_left  <= in_px[NW-1:0];
              row_len   <= in_px[NW-1:0];
              rows_left <= tri_rows[NW-1:0];
              step_left <= (cmd.direction == 2'd2) || (cmd.direction == 2'd3);
              step_up   <= (cmd.direction == 2'd0) || (cmd.direction == 2'd2);
              shrink    <= 1'b1;
            end
            default: begin
              cur_x     <= in_x;
              cur_y     <= in_y;
              row_x0    <= in_x;
              col_left  <= in_px[NW-1:0];
              row_len   <= in_px[NW-1:0];
              rows_left <= in_py[NW-1:0];
              step_left <= 1'b0;
              step_up   <= 1'b0;
              shrink    <= 1'b0;
            end
          endcase
        end
      end
      S_LINE_LOAD: begin
        cur_x <= seg_sx;
        cur_y <= seg_sy;
        end_x <= seg_ex;
        end_y <= seg_ey;
      end
      S_LINE_RUN: begin
        // Step each axis that has not yet reached its end by one cell.
        if (at_end) begin
          seg <= seg + 2'd1;
        end else begin
          if (cur_x < end_x) begin
            cur_x <= cur_x + CW'(1);
          end else if (cur_x > end_x) begin
            cur_x <= cur_x - CW'(1);
          end
          if (cur_y < end_y) begin
            cur_y <= cur_y + CW'(1);
          end else if (cur_y > end_y) begin
            cur_y <= cur_y - CW'(1);
          end
        end
      end
      S_FILL_RUN: begin
        if (!row_end) begin
          col_left <= col_left - NW'(1);
          cur_x    <= step_left ? cur_x - CW'(1) : cur_x + CW'(1);
        end else if (!last_row) begin
          rows_left <= rows_left - NW'(1);
          row_len   <= row_len_next;
          col_left  <= row_len_next;
          cur_x     <= row_x0;
          cur_y     <= step_up ? cur_y - CW'(1) : cur_y + CW'(1);
        end
      end
      S_READ_CAP: begin
        res_value <= rdata;
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == S_DONE && (!res.valid || res.ready)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res.valid || res.ready)) begin
      res.pixel_value <= res_value;
      res.outside     <= res_outside;
    end
  end

  crde_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (paint_glyph),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The store is only written while a shape is being walked.
  a_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_LINE_RUN || state == S_FILL_RUN))
    else $error("frame store written outside a walk");

  // Read data is captured only in the cycle after the read address was presented.
  a_read_order: assert property (@(posedge clk) disable iff (rst)
    state == S_READ_CAP |-> $past(state) == S_READ)
    else $error("read capture without a preceding read");

  // A raster walk never runs with an exhausted row or row count.
  a_fill_counts: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL_RUN |-> (col_left != '0 && rows_left != '0))
    else $error("fill walk with empty counters");

  // An accepted command always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("command accepted but sequencer stayed idle");

  // Only an outside read reports outside.
  a_outside_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_outside) |-> cmd_mode == MODE_READ)
    else $error("outside flag on a non-read command");

endmodule

@@ sv/crde_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module crde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/sv/tb_char_raster_draw_engine.sv @@
// Testbench of the character raster draw engine: directed and random commands with a predictor.
`timescale 1ns / 1ps

module tb_char_raster_draw_engine;
  import crde_pkg::*;

  logic clk;
  logic rst;

  crde_cmd_if cmd ();
  crde_res_if res ();

  char_raster_draw_engine uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd.sink),
    .res(res.source)
  );

  // One command beat and its expected answer.
  typedef struct packed {
    logic [2:0]        mode;
    logic signed [7:0] start_x;
    logic signed [7:0] start_y;
    logic signed [7:0] span_x;
    logic signed [7:0] span_y;
    logic [6:0]        upper_cut;
    logic [1:0]        direction;
    logic [7:0]        glyph;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       outside;
  } cell_answer_t;

  // Directed row: a command, and optionally a typed-in answer.
  typedef struct packed {
    draw_cmd_t    c;
    logic         fixed;
    cell_answer_t a;
  } directed_row_t;

  localparam int N_RANDOM    = 600;
  localparam int CYCLE_LIMIT = 3000000;

  // Predictor state: shadow frame store and record of written cells.
  logic [7:0]   shadow_store [DEPTH];
  bit           painted      [DEPTH];
  cell_answer_t pending_answers[$];

  int errors;
  int checked;
  int cycles;
  bit quiet_phase;
  bit stim_done;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // Paint one cell of the shadow store, dropping writes off the store.
  function automatic void paint(input int x, input int y, input logic [7:0] g);
    if (x >= 0 && x < COLS && y >= 0 && y < ROWS) begin
      shadow_store[y * COLS + x] = g;
      painted[y * COLS + x] = 1'b1;
    end
  endfunction

  // Diagonal run until one axis matches, then straight to the end point.
  function automatic void paint_line(input int x, input int y, input int ex, input int ey,
                                     input logic [7:0] g);
    int i;
    paint(x, y, g);
    paint(ex, ey, g);
    while (x != ex && y != ey) begin
      x += (x >= ex) ? -1 : 1;
      y += (y >= ey) ? -1 : 1;
      paint(x, y, g);
    end
    if (y == ey && x != ex) begin
      if (x > ex) for (i = x; i > ex; i--) paint(i, y, g);
      else        for (i = x; i < ex; i++) paint(i, y, g);
    end
    if (x == ex && y != ey) begin
      if (y > ey) for (i = y; i > ey; i--) paint(x, i, g);
      else        for (i = y; i < ey; i++) paint(x, i, g);
    end
  endfunction

  // Apply one command to the shadow store and return its answer.
  function automatic cell_answer_t draw_and_answer(input draw_cmd_t c);
    cell_answer_t a;
    int sx, sy, px, py, ddx, ddy, nrows, r, k;
    a  = '0;
    sx = c.start_x;
    sy = c.start_y;
    px = c.span_x;
    py = c.span_y;
    case (c.mode)
      MODE_CLEAR: begin
        for (k = 0; k < DEPTH; k++) begin
          shadow_store[k] = c.glyph;
          painted[k] = 1'b1;
        end
      end
      MODE_LINE: paint_line(sx, sy, px, py, c.glyph);
      MODE_FILL_RECT: begin
        for (r = sy; r < sy + py; r++)
          for (k = sx; k < sx + px; k++) paint(k, r, c.glyph);
      end
      MODE_OUT_RECT: begin
        paint_line(sx, sy, sx + px, sy, c.glyph);
        paint_line(sx + px, sy, sx + px, sy + py, c.glyph);
        paint_line(sx + px, sy + py, sx, sy + py, c.glyph);
        paint_line(sx, sy + py, sx, sy, c.glyph);
      end
      MODE_FILL_TRI: begin
        nrows = px - int'(c.upper_cut);
        ddy = (c.direction == 2'd1 || c.direction == 2'd3) ? 1 : -1;
        ddx = (c.direction == 2'd2 || c.direction == 2'd3) ? -1 : 1;
        for (r = 0; r < nrows; r++)
          for (k = 0; k < px - r; k++) paint(sx + ddx * k, sy + ddy * r, c.glyph);
      end
      MODE_OUT_TRI: begin
        ddx = (c.direction == 2'd2 || c.direction == 2'd3) ? -px : px;
        ddy = (c.direction == 2'd1 || c.direction == 2'd2) ? py : -py;
        paint_line(sx + ddx, sy, sx, sy + ddy, c.glyph);
        paint_line(sx, sy, sx + ddx, sy, c.glyph);
        paint_line(sx, sy, sx, sy + ddy, c.glyph);
      end
      MODE_READ: begin
        if (sx >= 0 && sx < COLS && sy >= 0 && sy < ROWS)
          a.pixel_value = shadow_store[sy * COLS + sx];
        else
          a.outside = 1'b1;
      end
      default: ;
    endcase
    return a;
  endfunction

  // Random burst length for idling on either side.
  function automatic int idle_burst();
    if (quiet_phase || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 19);
  endfunction

  // Send one command, waiting out the handshake. Valid drops only when a gap follows.
  task automatic send_cmd(input draw_cmd_t c, input bit fixed, input cell_answer_t a);
    cell_answer_t want;
    int gap;
    gap = idle_burst();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.mode      <= c.mode;
    cmd.start_x   <= c.start_x;
    cmd.start_y   <= c.start_y;
    cmd.span_x    <= c.span_x;
    cmd.span_y    <= c.span_y;
    cmd.upper_cut <= c.upper_cut;
    cmd.direction <= c.direction;
    cmd.glyph     <= c.glyph;
    cmd.valid     <= 1'b1;
    do @(posedge clk); while (!cmd.ready);
    want = draw_and_answer(c);
    if (fixed && want != a)
      report_mismatch("directed table answer vs predictor", want, a);
    pending_answers.push_back(fixed ? a : want);
    @(negedge clk);
  endtask

  // Random shape coordinates: mostly near the store, sometimes anywhere.
  function automatic logic signed [7:0] rand_coord(input int hi);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, hi + 8) - 4);
  endfunction

  function automatic logic signed [7:0] rand_span();
    if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 30) - 6);
  endfunction

  // Read a cell that has been written, or one off the store.
  function automatic draw_cmd_t rand_read();
    draw_cmd_t c;
    int k, tries;
    c = '0;
    c.mode = MODE_READ;
    c.glyph = 8'($urandom);
    c.upper_cut = 7'($urandom);
    c.direction = 2'($urandom);
    c.span_x = 8'($urandom);
    c.span_y = 8'($urandom);
    if ($urandom_range(0, 5) == 0) begin
      c.start_x = 8'($urandom_range(COLS, 255));
      c.start_y = 8'($urandom);
      return c;
    end
    for (tries = 0; tries < 50; tries++) begin
      k = $urandom_range(0, DEPTH - 1);
      if (painted[k]) break;
    end
    if (!painted[k]) k = 0;
    c.start_x = 8'(k % COLS);
    c.start_y = 8'(k / COLS);
    return c;
  endfunction

  function automatic draw_cmd_t rand_draw();
    draw_cmd_t c;
    c.mode      = 3'($urandom_range(MODE_LINE, MODE_OUT_TRI));
    if ($urandom_range(0, 40) == 0) c.mode = MODE_CLEAR;
    if ($urandom_range(0, 40) == 0) c.mode = 3'd7;
    c.start_x   = rand_coord(COLS);
    c.start_y   = rand_coord(ROWS);
    c.span_x    = (c.mode == MODE_LINE) ? rand_coord(COLS) : rand_span();
    c.span_y    = (c.mode == MODE_LINE) ? rand_coord(ROWS) : rand_span();
    c.upper_cut = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12));
    c.direction = 2'($urandom);
    c.glyph     = 8'($urandom);
    return c;
  endfunction

  // Directed table: clear first so every later in-store read hits written cells.
  directed_row_t directed_rows[] = '{
    '{'{MODE_CLEAR,     8'sd0,    8'sd0,   8'sd0,    8'sd0,   7'd0,   2'd0, 8'hA5}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_READ,      8'sd0,    8'sd0,   8'sd0,    8'sd0,   7'd0,   2'd0, 8'h00}, 1'b1, '{8'hA5, 1'b0}},
    '{'{MODE_READ,      8'sd49,   8'sd19,  8'sd0,    8'sd0,   7'd0,   2'd0, 8'h00}, 1'b1, '{8'hA5, 1'b0}},
    '{'{MODE_READ,      8'sd50,   8'sd0,   8'sd0,    8'sd0,   7'd0,   2'd0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{MODE_READ,      8'sd0,    8'sd20,  8'sd0,    8'sd0,   7'd0,   2'd0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{MODE_READ,     -8'sd1,    8'sd0,   8'sd0,    8'sd0,   7'd0,   2'd0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{MODE_READ,     -8'sd128, -8'sd128, 8'sd127,  8'sd127, 7'd127, 2'd3, 8'hFF}, 1'b1, '{8'h00, 1'b1}},
    '{'{3'd7,           8'sd127,  8'sd127, 8'sd127,  8'sd127, 7'd127, 2'd3, 8'hFF}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_LINE,      8'sd2,    8'sd3,   8'sd40,   8'sd10,  7'd0,   2'd0, 8'h11}, 1'b0, '0},
    '{'{MODE_LINE,     -8'sd128,  8'sd127, 8'sd127, -8'sd128, 7'd0,   2'd0, 8'h22}, 1'b0, '0},
    '{'{MODE_FILL_RECT, 8'sd45,   8'sd15,  8'sd10,   8'sd10,  7'd0,   2'd0, 8'h33}, 1'b0, '0},
    '{'{MODE_FILL_RECT, 8'sd5,    8'sd5,  -8'sd3,    8'sd4,   7'd0,   2'd0, 8'hEE}, 1'b0, '0},
    '{'{MODE_OUT_RECT,  8'sd1,    8'sd1,   8'sd0,    8'sd0,   7'd0,   2'd0, 8'h44}, 1'b0, '0},
    '{'{MODE_OUT_RECT, -8'sd5,   -8'sd5,   8'sd60,   8'sd30,  7'd0,   2'd0, 8'h55}, 1'b0, '0},
    '{'{MODE_FILL_TRI,  8'sd10,   8'sd10,  8'sd8,    8'sd0,   7'd2,   2'd0, 8'h66}, 1'b0, '0},
    '{'{MODE_FILL_TRI,  8'sd10,   8'sd10,  8'sd8,    8'sd0,   7'd0,   2'd1, 8'h67}, 1'b0, '0},
    '{'{MODE_FILL_TRI,  8'sd30,   8'sd10,  8'sd6,    8'sd0,   7'd1,   2'd2, 8'h68}, 1'b0, '0},
    '{'{MODE_FILL_TRI,  8'sd30,   8'sd10,  8'sd6,    8'sd0,   7'd3,   2'd3, 8'h69}, 1'b0, '0},
    '{'{MODE_FILL_TRI,  8'sd20,   8'sd5,   8'sd4,    8'sd0,   7'd4,   2'd0, 8'h6A}, 1'b0, '0},
    '{'{MODE_OUT_TRI,   8'sd25,   8'sd10,  8'sd5,    8'sd4,   7'd0,   2'd0, 8'h77}, 1'b0, '0},
    '{'{MODE_OUT_TRI,   8'sd25,   8'sd10,  8'sd5,    8'sd4,   7'd0,   2'd1, 8'h78}, 1'b0, '0},
    '{'{MODE_OUT_TRI,   8'sd25,   8'sd10,  8'sd5,    8'sd4,   7'd0,   2'd2, 8'h79}, 1'b0, '0},
    '{'{MODE_OUT_TRI,   8'sd25,   8'sd10, -8'sd6,   -8'sd3,   7'd0,   2'd3, 8'h7A}, 1'b0, '0},
    '{'{MODE_READ,      8'sd12,   8'sd10,  8'sd0,    8'sd0,   7'd0,   2'd0, 8'h00}, 1'b0, '0},
    '{'{MODE_READ,      8'sd25,   8'sd10,  8'sd0,    8'sd0,   7'd0,   2'd0, 8'h00}, 1'b0, '0}
  };

  // Stimulus.
  initial begin
    draw_cmd_t c;
    int n;
    errors = 0;
    checked = 0;
    quiet_phase = 1'b0;
    stim_done = 1'b0;
    for (n = 0; n < DEPTH; n++) begin
      shadow_store[n] = '0;
      painted[n] = 1'b0;
    end
    cmd.valid = 1'b0;
    cmd.mode = '0;
    cmd.start_x = '0;
    cmd.start_y = '0;
    cmd.span_x = '0;
    cmd.span_y = '0;
    cmd.upper_cut = '0;
    cmd.direction = '0;
    cmd.glyph = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].c, directed_rows[i].fixed, directed_rows[i].a);

    for (n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 60) quiet_phase = 1'b1;
      c = ($urandom_range(0, 2) == 0) ? rand_read() : rand_draw();
      send_cmd(c, 1'b0, '0);
    end
    cmd.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls and checking. Ready drops only when a stall follows.
  initial begin
    cell_answer_t want;
    int stall;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_burst();
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      if (pending_answers.size() == 0) begin
        errors++;
        $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        want = pending_answers.pop_front();
        checked++;
        if (res.pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", res.pixel_value, want.pixel_value);
        if (res.outside !== want.outside)
          report_mismatch("outside", res.outside, want.outside);
      end
      @(negedge clk);
    end
  end

  // End of run.
  initial begin
    @(negedge clk);
    wait (stim_done);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DEPTH + 50) @(posedge clk);
    $display("ran %0d commands and checked %0d result beats", directed_rows.size() + N_RANDOM,
             checked);
    $display("covered all draw modes, all orientations, off-store writes and reads");
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
